@@ hdl/vcsl_pkg.sv @@
// Shared constants, types and helpers for the velocity command slew limiter.
package vcsl_pkg;

    // Velocity word width (signed Q4.12 at 16 bits)
    localparam int VELOCITY_WIDTH = 16;

    // Configuration register widths
    localparam int LIN_W      = 15;
    localparam int SCALE_W    = 16;
    localparam int SPIN_W     = 15;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SCALE_FRAC = 14;

    // Derived datapath widths
    localparam int LIM_W    = LIN_W + SCALE_W - SCALE_FRAC;
    localparam int MUL_W    = (VELOCITY_WIDTH > LIM_W) ? VELOCITY_WIDTH : LIM_W;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DIFF_W   = VELOCITY_WIDTH + 1;
    localparam int ROOT_W   = VELOCITY_WIDTH + 1;
    localparam int RAD_W    = 2 * VELOCITY_WIDTH + 2;
    localparam int SQ_REM_W = VELOCITY_WIDTH + 2;
    localparam int SUB_W    = VELOCITY_WIDTH + 4;
    localparam int CMP_W    = (ROOT_W > LIM_W) ? ROOT_W : LIM_W;
    localparam int EXT_W    = ((VELOCITY_WIDTH > SPIN_W) ? VELOCITY_WIDTH : SPIN_W) + 2;
    localparam int CNT_W    = $clog2(ROOT_W + 1);

    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(VELOCITY_WIDTH - 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_STEP   = 2'd2;

    // Register reset values
    localparam logic [LIN_W-1:0]   LINEAR_STEP_RESET = 15'd41;
    localparam logic [SCALE_W-1:0] TURN_SCALE_RESET  = 16'd16384;
    localparam logic [SPIN_W-1:0]  SPIN_STEP_RESET   = 15'd41;

    // Large-turn limiter phase
    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_WAIT  = 2'd1,
        PH_TRANS = 2'd2
    } phase_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LIM_MUL,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_SUM,
        ST_ROOT,
        ST_CHECK,
        ST_DIV_MUL,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LIN_W-1:0]   linear_step;
        logic [SCALE_W-1:0] turn_scale;
        logic [SPIN_W-1:0]  spin_step;
    } cfg_t;

    typedef struct packed {
        logic signed [VELOCITY_WIDTH-1:0] vx;
        logic signed [VELOCITY_WIDTH-1:0] vy;
        logic signed [VELOCITY_WIDTH-1:0] wz;
        phase_t                           phase;
        logic                             limited;
    } result_t;

    typedef struct packed {
        logic [MUL_W-1:0] mul_a;
        logic [MUL_W-1:0] mul_b;
        logic [SUB_W-1:0] sub_a;
        logic [SUB_W-1:0] sub_b;
    } alu_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        logic [SUB_W-1:0]  diff;
        logic              ge;
    } alu_rsp_t;

    // Clamp a widened sum to the signed velocity range
    function automatic logic signed [VELOCITY_WIDTH-1:0] sat_vel(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(signed'({1'b0, {(VELOCITY_WIDTH-1){1'b1}}}));
        lo = EXT_W'(signed'({1'b1, {(VELOCITY_WIDTH-1){1'b0}}}));
        priority if (v > hi)
        begin
            sat_vel = hi[VELOCITY_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            sat_vel = lo[VELOCITY_WIDTH-1:0];
        end
        else
        begin
            sat_vel = v[VELOCITY_WIDTH-1:0];
        end
    endfunction

endpackage

@@ hdl/vcsl_alu.sv @@
// Shared arithmetic unit: one multiplier and one trial subtractor.
module vcsl_alu (
    input  vcsl_pkg::alu_req_t req,
    output vcsl_pkg::alu_rsp_t rsp
);

    // Multiply, and subtract with a no-borrow flag for the digit steps
    always_comb
    begin
        rsp.product = vcsl_pkg::PROD_W'(req.mul_a) * vcsl_pkg::PROD_W'(req.mul_b);
        rsp.diff    = req.sub_a - req.sub_b;
        rsp.ge      = (req.sub_a >= req.sub_b);
    end

endmodule

@@ hdl/vcsl_core.sv @@
// Sequencer and state registers: square root, scaling divides and step update.
module vcsl_core (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_take,
    input  logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] goal_vx,
    input  logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] goal_vy,
    input  logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] goal_wz,
    input  logic                                      is_armed,
    input  logic                                      limiter_write,
    input  logic                                      limiter_enable,
    input  vcsl_pkg::cfg_t                            cfg,
    output logic                                      idle,
    output logic                                      res_valid,
    input  logic                                      res_ready,
    output vcsl_pkg::result_t                         res
);

    localparam int W = vcsl_pkg::VELOCITY_WIDTH;

    vcsl_pkg::state_t state_reg, state_next;
    vcsl_pkg::phase_t phase_reg, phase_next;

    logic                                armed_reg, armed_next;
    logic                                limited_reg, limited_next;
    logic                                sel_y_reg, sel_y_next;
    logic signed [W-1:0]                 goal_vx_reg, goal_vx_next;
    logic signed [W-1:0]                 goal_vy_reg, goal_vy_next;
    logic signed [W-1:0]                 goal_wz_reg, goal_wz_next;
    logic signed [W-1:0]                 smooth_vx_reg, smooth_vx_next;
    logic signed [W-1:0]                 smooth_vy_reg, smooth_vy_next;
    logic signed [W-1:0]                 smooth_wz_reg, smooth_wz_next;
    logic signed [vcsl_pkg::DIFF_W-1:0]  dx_reg, dx_next;
    logic signed [vcsl_pkg::DIFF_W-1:0]  dy_reg, dy_next;
    logic [vcsl_pkg::LIM_W-1:0]          lim_reg, lim_next;
    logic [vcsl_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [vcsl_pkg::RAD_W-1:0]          rad_reg, rad_next;
    logic [vcsl_pkg::ROOT_W-1:0]         root_reg, root_next;
    logic [vcsl_pkg::SQ_REM_W-1:0]       rem_reg, rem_next;
    logic [vcsl_pkg::ROOT_W-1:0]         drem_reg, drem_next;
    logic [W-1:0]                        num_reg, num_next;
    logic [W-1:0]                        quo_reg, quo_next;
    logic [vcsl_pkg::CNT_W-1:0]          cnt_reg, cnt_next;

    vcsl_pkg::alu_req_t alu_req;
    vcsl_pkg::alu_rsp_t alu_rsp;

    logic [W-1:0]                       ax;
    logic [W-1:0]                       ay;
    logic [W-1:0]                       cur_mag;
    logic                               cur_neg;
    logic                               need_scale;
    logic [W-1:0]                       quo_bits;
    logic signed [vcsl_pkg::DIFF_W-1:0] q_signed;
    logic signed [vcsl_pkg::EXT_W-1:0]  spin_cur;
    logic signed [vcsl_pkg::EXT_W-1:0]  spin_k;
    logic signed [vcsl_pkg::EXT_W-1:0]  spin_goal;
    logic signed [vcsl_pkg::EXT_W-1:0]  spin_up;
    logic signed [vcsl_pkg::EXT_W-1:0]  spin_dn;

    vcsl_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Magnitudes of the planar change and the operand of the current divide
    assign ax      = dx_reg[W] ? W'(-dx_reg) : W'(dx_reg);
    assign ay      = dy_reg[W] ? W'(-dy_reg) : W'(dy_reg);
    assign cur_mag = sel_y_reg ? ay : ax;
    assign cur_neg = sel_y_reg ? dy_reg[W] : dx_reg[W];

    // Change exceeds the limit when d2 > lim^2, read off the root and remainder
    assign need_scale =
        (vcsl_pkg::CMP_W'(root_reg) > vcsl_pkg::CMP_W'(lim_reg)) ||
        ((vcsl_pkg::CMP_W'(root_reg) == vcsl_pkg::CMP_W'(lim_reg)) && (rem_reg != '0));

    // Quotient including this step's digit, and its signed form
    assign quo_bits = {quo_reg[W-2:0], alu_rsp.ge};
    assign q_signed = signed'({1'b0, quo_bits});

    // Spin clamp bounds
    assign spin_cur  = vcsl_pkg::EXT_W'(smooth_wz_reg);
    assign spin_k    = signed'(vcsl_pkg::EXT_W'(cfg.spin_step));
    assign spin_goal = vcsl_pkg::EXT_W'(goal_wz_reg);
    assign spin_up   = spin_cur + spin_k;
    assign spin_dn   = spin_cur - spin_k;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vcsl_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = vcsl_pkg::ST_PREP;
                end
            end
            vcsl_pkg::ST_PREP:
            begin
                state_next = armed_reg ? vcsl_pkg::ST_LIM_MUL : vcsl_pkg::ST_DONE;
            end
            vcsl_pkg::ST_LIM_MUL:  state_next = vcsl_pkg::ST_SQ_X;
            vcsl_pkg::ST_SQ_X:     state_next = vcsl_pkg::ST_SQ_Y;
            vcsl_pkg::ST_SQ_Y:     state_next = vcsl_pkg::ST_SQ_SUM;
            vcsl_pkg::ST_SQ_SUM:   state_next = vcsl_pkg::ST_ROOT;
            vcsl_pkg::ST_ROOT:
            begin
                if (cnt_reg == vcsl_pkg::ROOT_LAST)
                begin
                    state_next = vcsl_pkg::ST_CHECK;
                end
            end
            vcsl_pkg::ST_CHECK:
            begin
                state_next = need_scale ? vcsl_pkg::ST_DIV_MUL : vcsl_pkg::ST_APPLY;
            end
            vcsl_pkg::ST_DIV_MUL:  state_next = vcsl_pkg::ST_DIV_LOAD;
            vcsl_pkg::ST_DIV_LOAD: state_next = vcsl_pkg::ST_DIV_RUN;
            vcsl_pkg::ST_DIV_RUN:
            begin
                if (cnt_reg == vcsl_pkg::DIV_LAST)
                begin
                    state_next = sel_y_reg ? vcsl_pkg::ST_APPLY : vcsl_pkg::ST_DIV_MUL;
                end
            end
            vcsl_pkg::ST_APPLY:    state_next = vcsl_pkg::ST_DONE;
            vcsl_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = vcsl_pkg::ST_IDLE;
                end
            end
            default:               state_next = vcsl_pkg::ST_IDLE;
        endcase
    end

    // Datapath control: drive the shared unit and compute register updates
    always_comb
    begin
        alu_req        = '0;
        phase_next     = phase_reg;
        armed_next     = armed_reg;
        limited_next   = limited_reg;
        sel_y_next     = sel_y_reg;
        goal_vx_next   = goal_vx_reg;
        goal_vy_next   = goal_vy_reg;
        goal_wz_next   = goal_wz_reg;
        smooth_vx_next = smooth_vx_reg;
        smooth_vy_next = smooth_vy_reg;
        smooth_wz_next = smooth_wz_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        lim_next       = lim_reg;
        prod_next      = prod_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        drem_next      = drem_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;

        unique case (state_reg)
            vcsl_pkg::ST_IDLE:
            begin
                // Capture the request; a limiter write acts on this tick
                if (in_take)
                begin
                    goal_vx_next = goal_vx;
                    goal_vy_next = goal_vy;
                    goal_wz_next = goal_wz;
                    armed_next   = is_armed;
                    if (limiter_write)
                    begin
                        phase_next = limiter_enable ? vcsl_pkg::PH_WAIT : vcsl_pkg::PH_OFF;
                    end
                end
            end
            vcsl_pkg::ST_PREP:
            begin
                // Form the planar change, or drop everything when disarmed
                dx_next      = vcsl_pkg::DIFF_W'(goal_vx_reg) - vcsl_pkg::DIFF_W'(smooth_vx_reg);
                dy_next      = vcsl_pkg::DIFF_W'(goal_vy_reg) - vcsl_pkg::DIFF_W'(smooth_vy_reg);
                limited_next = 1'b0;
                if (!armed_reg)
                begin
                    smooth_vx_next = '0;
                    smooth_vy_next = '0;
                    smooth_wz_next = '0;
                    phase_next     = vcsl_pkg::PH_OFF;
                end
            end
            vcsl_pkg::ST_LIM_MUL:
            begin
                alu_req.mul_a = vcsl_pkg::MUL_W'(cfg.linear_step);
                alu_req.mul_b = vcsl_pkg::MUL_W'(cfg.turn_scale);
                prod_next     = alu_rsp.product;
            end
            vcsl_pkg::ST_SQ_X:
            begin
                // Pick the planar limit, start dx squared
                if (phase_reg != vcsl_pkg::PH_OFF)
                begin
                    lim_next = prod_reg[vcsl_pkg::SCALE_FRAC +: vcsl_pkg::LIM_W];
                end
                else
                begin
                    lim_next = vcsl_pkg::LIM_W'(cfg.linear_step);
                end
                alu_req.mul_a = vcsl_pkg::MUL_W'(ax);
                alu_req.mul_b = vcsl_pkg::MUL_W'(ax);
                prod_next     = alu_rsp.product;
            end
            vcsl_pkg::ST_SQ_Y:
            begin
                rad_next      = vcsl_pkg::RAD_W'(prod_reg);
                alu_req.mul_a = vcsl_pkg::MUL_W'(ay);
                alu_req.mul_b = vcsl_pkg::MUL_W'(ay);
                prod_next     = alu_rsp.product;
            end
            vcsl_pkg::ST_SQ_SUM:
            begin
                rad_next  = rad_reg + vcsl_pkg::RAD_W'(prod_reg);
                root_next = '0;
                rem_next  = '0;
                cnt_next  = '0;
            end
            vcsl_pkg::ST_ROOT:
            begin
                // One root digit per cycle: try subtracting 4*root+1
                alu_req.sub_a = vcsl_pkg::SUB_W'({rem_reg, rad_reg[vcsl_pkg::RAD_W-1 -: 2]});
                alu_req.sub_b = vcsl_pkg::SUB_W'({root_reg, 2'b01});
                rad_next      = rad_reg << 2;
                cnt_next      = cnt_reg + 1'b1;
                if (alu_rsp.ge)
                begin
                    rem_next  = alu_rsp.diff[vcsl_pkg::SQ_REM_W-1:0];
                    root_next = {root_reg[vcsl_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = alu_req.sub_a[vcsl_pkg::SQ_REM_W-1:0];
                    root_next = {root_reg[vcsl_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            vcsl_pkg::ST_CHECK:
            begin
                // Advance the large-turn limiter on the outcome
                limited_next = need_scale;
                sel_y_next   = 1'b0;
                if (need_scale && (phase_reg == vcsl_pkg::PH_WAIT))
                begin
                    phase_next = vcsl_pkg::PH_TRANS;
                end
                else if (!need_scale && (phase_reg == vcsl_pkg::PH_TRANS))
                begin
                    phase_next = vcsl_pkg::PH_OFF;
                end
            end
            vcsl_pkg::ST_DIV_MUL:
            begin
                alu_req.mul_a = vcsl_pkg::MUL_W'(cur_mag);
                alu_req.mul_b = vcsl_pkg::MUL_W'(lim_reg);
                prod_next     = alu_rsp.product;
            end
            vcsl_pkg::ST_DIV_LOAD:
            begin
                // Upper part is already below the root, so only W digits remain
                drem_next = vcsl_pkg::ROOT_W'(prod_reg >> W);
                num_next  = prod_reg[W-1:0];
                quo_next  = '0;
                cnt_next  = '0;
            end
            vcsl_pkg::ST_DIV_RUN:
            begin
                // One quotient digit per cycle against the root
                alu_req.sub_a = vcsl_pkg::SUB_W'({drem_reg, num_reg[W-1]});
                alu_req.sub_b = vcsl_pkg::SUB_W'(root_reg);
                num_next      = num_reg << 1;
                quo_next      = quo_bits;
                cnt_next      = cnt_reg + 1'b1;
                if (alu_rsp.ge)
                begin
                    drem_next = alu_rsp.diff[vcsl_pkg::ROOT_W-1:0];
                end
                else
                begin
                    drem_next = alu_req.sub_a[vcsl_pkg::ROOT_W-1:0];
                end
                if (cnt_reg == vcsl_pkg::DIV_LAST)
                begin
                    sel_y_next = 1'b1;
                    if (sel_y_reg)
                    begin
                        dy_next = cur_neg ? -q_signed : q_signed;
                    end
                    else
                    begin
                        dx_next = cur_neg ? -q_signed : q_signed;
                    end
                end
            end
            vcsl_pkg::ST_APPLY:
            begin
                // Step the held command and clamp the spin rate
                smooth_vx_next = vcsl_pkg::sat_vel(vcsl_pkg::EXT_W'(smooth_vx_reg)
                                                   + vcsl_pkg::EXT_W'(dx_reg));
                smooth_vy_next = vcsl_pkg::sat_vel(vcsl_pkg::EXT_W'(smooth_vy_reg)
                                                   + vcsl_pkg::EXT_W'(dy_reg));
                priority if (spin_goal > spin_up)
                begin
                    smooth_wz_next = vcsl_pkg::sat_vel(spin_up);
                end
                else if (spin_goal < spin_dn)
                begin
                    smooth_wz_next = vcsl_pkg::sat_vel(spin_dn);
                end
                else
                begin
                    smooth_wz_next = goal_wz_reg;
                end
            end
            vcsl_pkg::ST_DONE:
            begin
                // Hold until the output register takes the result
            end
            default:
            begin
            end
        endcase
    end

    // Control and held command state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vcsl_pkg::ST_IDLE;
            phase_reg     <= vcsl_pkg::PH_OFF;
            smooth_vx_reg <= '0;
            smooth_vy_reg <= '0;
            smooth_wz_reg <= '0;
            cnt_reg       <= '0;
            sel_y_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            smooth_vx_reg <= smooth_vx_next;
            smooth_vy_reg <= smooth_vy_next;
            smooth_wz_reg <= smooth_wz_next;
            cnt_reg       <= cnt_next;
            sel_y_reg     <= sel_y_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        armed_reg   <= armed_next;
        limited_reg <= limited_next;
        goal_vx_reg <= goal_vx_next;
        goal_vy_reg <= goal_vy_next;
        goal_wz_reg <= goal_wz_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        lim_reg     <= lim_next;
        prod_reg    <= prod_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        drem_reg    <= drem_next;
        num_reg     <= num_next;
        quo_reg     <= quo_next;
    end

    // Result and handshake status
    assign idle        = (state_reg == vcsl_pkg::ST_IDLE);
    assign res_valid   = (state_reg == vcsl_pkg::ST_DONE);
    assign res.vx      = smooth_vx_reg;
    assign res.vy      = smooth_vy_reg;
    assign res.wz      = smooth_wz_reg;
    assign res.phase   = phase_reg;
    assign res.limited = limited_reg;

endmodule

@@ hdl/velocity_command_slew_limiter.sv @@
// Top level: configuration registers, request intake and output register.
// A disarmed request skips the arithmetic; an armed one runs the 17-step square root and,
// when the planar change exceeds the limit, also two 16-step divides, all through the one
// shared subtractor. A new request is taken only once the last result has moved to the
// output register and the sequencer is idle again.
// Reset clears the held command, the limiter to off, and the registers to defaults.
module velocity_command_slew_limiter (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] goal_vx,
    input  logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] goal_vy,
    input  logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] goal_wz,
    input  logic                                      is_armed,
    input  logic                                      limiter_write,
    input  logic                                      limiter_enable,
    input  logic                                      cfg_write,
    input  logic [vcsl_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [vcsl_pkg::CFG_W-1:0]                cfg_data,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] held_vx,
    output logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] held_vy,
    output logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] held_wz,
    output logic [1:0]                                limiter_phase,
    output logic                                      was_limited
);

    vcsl_pkg::cfg_t    cfg_reg;
    vcsl_pkg::result_t res;
    vcsl_pkg::result_t result_reg;

    logic core_idle;
    logic res_valid;
    logic res_ready;
    logic in_take;
    logic out_valid_reg, out_valid_next;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear_step <= vcsl_pkg::LINEAR_STEP_RESET;
            cfg_reg.turn_scale  <= vcsl_pkg::TURN_SCALE_RESET;
            cfg_reg.spin_step   <= vcsl_pkg::SPIN_STEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                vcsl_pkg::REG_LINEAR_STEP: cfg_reg.linear_step <= cfg_data[vcsl_pkg::LIN_W-1:0];
                vcsl_pkg::REG_TURN_SCALE:  cfg_reg.turn_scale  <= cfg_data[vcsl_pkg::SCALE_W-1:0];
                vcsl_pkg::REG_SPIN_STEP:   cfg_reg.spin_step   <= cfg_data[vcsl_pkg::SPIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Take a request only while the sequencer is idle
    assign in_stall = !core_idle;
    assign in_take  = in_valid && core_idle;

    vcsl_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_take        (in_take),
        .goal_vx        (goal_vx),
        .goal_vy        (goal_vy),
        .goal_wz        (goal_wz),
        .is_armed       (is_armed),
        .limiter_write  (limiter_write),
        .limiter_enable (limiter_enable),
        .cfg            (cfg_reg),
        .idle           (core_idle),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // Output register: load when empty or being drained
    assign res_ready      = !out_valid_reg || !out_stall;
    assign out_valid_next = res_ready ? res_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign held_vx       = result_reg.vx;
    assign held_vy       = result_reg.vy;
    assign held_wz       = result_reg.wz;
    assign limiter_phase = result_reg.phase;
    assign was_limited   = result_reg.limited;

endmodule

@@ hdl/vcsl_checker.sv @@
// Port-level checker for the velocity command slew limiter, bound to the top level.
module vcsl_checker (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      in_valid,
    input logic                                      in_stall,
    input logic                                      out_valid,
    input logic                                      out_stall,
    input logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] held_vx,
    input logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] held_vy,
    input logic signed [vcsl_pkg::VELOCITY_WIDTH-1:0] held_wz,
    input logic [1:0]                                limiter_phase,
    input logic                                      was_limited
);

    // A taken request keeps the intake closed while it is worked on
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("intake open right after a request was taken");

    // No result can appear in the cycle right after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !$rose(out_valid))
        else $error("result appeared too soon after a request");

    // A transition phase only follows a scaled planar step
    a_trans_needs_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !was_limited) |-> (limiter_phase != vcsl_pkg::PH_TRANS))
        else $error("transition phase without a limited step");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(held_vx) && $stable(held_vy)
            && $stable(held_wz) && $stable(limiter_phase) && $stable(was_limited)))
        else $error("stalled result changed");

endmodule

bind velocity_command_slew_limiter vcsl_checker u_vcsl_checker (.*);
